// ===== src/rtcse_pkg.sv =====
package rtcse_pkg;

	localparam int HISTORY_DEPTH = 32;

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int ACC_W = 32 + IDX_W + 1;

	localparam int TICK_W = 32;
	localparam int PING_W = 31;
	localparam int OFF_W  = 32;
	localparam int STAT_W = 32;
	localparam int FILL_W = 9;
	localparam int RTT_W  = 31;
	localparam int PINGX_W = 34;

	// floor(rtt*3/5) = (rtt * RECIP_3_5) >> RECIP_SHIFT for any rtt below 2^31
	localparam int RPROD_W     = 64;
	localparam int RECIP_SHIFT = 33;

	localparam int DVS_W = (CNT_W > 3) ? CNT_W : 3;
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_STEPS = (ACC_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
	localparam int DIV_W = DIV_STEPS * DIV_RADIX_BITS;
	localparam int DSTEP_W = $clog2(DIV_STEPS + 1);

	localparam logic [PING_W-1:0]        PING_SAT       = '1;
	localparam logic signed [OFF_W-1:0]  DEADBAND       = 32'sd10;
	localparam logic [PINGX_W-1:0]       PING_SCALE     = 34'd5;
	localparam logic [RPROD_W-1:0]       RECIP_3_5      = 64'h0000_0001_3333_3334;
	localparam logic [STAT_W-1:0]        EMPTY_MIN      = '1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [1:0] DIV_SEL_OFF  = 2'd1;
	localparam logic [1:0] DIV_SEL_PING = 2'd2;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       rtt;
		logic       scale;
		logic       div_start;
		logic [1:0] div_sel;
		logic       commit;
		logic       walk_start;
		logic       walk_step;
		logic       result_load;
	} rtcse_cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
	} rtcse_sts_t;

endpackage

// ===== src/rtcse_sample_if.sv =====
interface rtcse_sample_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [rtcse_pkg::TICK_W-1:0]    sent_tick;
	logic [rtcse_pkg::TICK_W-1:0]    server_tick;
	logic [rtcse_pkg::TICK_W-1:0]    local_tick;

	modport source(output valid, command, sent_tick, server_tick, local_tick, input ready);
	modport sink(input valid, command, sent_tick, server_tick, local_tick, output ready);
endinterface

// ===== src/rtcse_result_if.sv =====
interface rtcse_result_if;
	logic                            valid;
	logic                            ready;
	logic [rtcse_pkg::PING_W-1:0]    ping_now;
	logic [rtcse_pkg::OFF_W-1:0]     offset_mean;
	logic [rtcse_pkg::STAT_W-1:0]    ping_mean;
	logic [rtcse_pkg::STAT_W-1:0]    ping_min;
	logic [rtcse_pkg::STAT_W-1:0]    ping_max;
	logic [rtcse_pkg::FILL_W-1:0]    filled_count;

	modport source(output valid, ping_now, offset_mean, ping_mean, ping_min, ping_max,
		filled_count, input ready);
	modport sink(input valid, ping_now, offset_mean, ping_mean, ping_min, ping_max,
		filled_count, output ready);
endinterface

// ===== src/rtcse_div.sv =====
module rtcse_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rtcse_pkg::DIV_W-1:0]    dividend,
	input  logic [rtcse_pkg::DVS_W-1:0]    divisor,
	output logic                           done,
	output logic [rtcse_pkg::DIV_W-1:0]    quotient
);

	logic [rtcse_pkg::DIV_W-1:0]   num_q;
	logic [rtcse_pkg::DVS_W-1:0]   rem_q;
	logic [rtcse_pkg::DVS_W-1:0]   dvs_q;
	logic [rtcse_pkg::DSTEP_W-1:0] step_q;
	logic                          done_q;

	logic [rtcse_pkg::DIV_W-1:0]   num_n;
	logic [rtcse_pkg::DVS_W:0]     rem_w;

	// restoring division, DIV_RADIX_BITS quotient bits per cycle
	always_comb begin
		num_n = num_q;
		rem_w = {1'b0, rem_q};
		for (int k = 0; k < rtcse_pkg::DIV_RADIX_BITS; k++) begin
			rem_w = {rem_w[rtcse_pkg::DVS_W-1:0], num_n[rtcse_pkg::DIV_W-1]};
			num_n = {num_n[rtcse_pkg::DIV_W-2:0], 1'b0};
			if (rem_w >= {1'b0, dvs_q}) begin
				rem_w = rem_w - {1'b0, dvs_q};
				num_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == rtcse_pkg::DSTEP_W'(1)) && !start;
			if (start) begin
				step_q <= rtcse_pkg::DSTEP_W'(rtcse_pkg::DIV_STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			num_q <= num_n;
			rem_q <= rem_w[rtcse_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== src/rtcse_dp.sv =====
module rtcse_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtcse_pkg::rtcse_cmd_t           cmd,
	output rtcse_pkg::rtcse_sts_t           sts,
	input  logic [rtcse_pkg::TICK_W-1:0]    sent_tick,
	input  logic [rtcse_pkg::TICK_W-1:0]    server_tick,
	input  logic [rtcse_pkg::TICK_W-1:0]    local_tick,
	output logic [rtcse_pkg::PING_W-1:0]    ping_now,
	output logic [rtcse_pkg::OFF_W-1:0]     offset_mean,
	output logic [rtcse_pkg::STAT_W-1:0]    ping_mean,
	output logic [rtcse_pkg::STAT_W-1:0]    ping_min,
	output logic [rtcse_pkg::STAT_W-1:0]    ping_max,
	output logic [rtcse_pkg::FILL_W-1:0]    filled_count
);

	logic [rtcse_pkg::TICK_W-1:0] sent_q, server_q, local_q;
	logic [rtcse_pkg::PING_W-1:0] ping_new_q;
	logic [rtcse_pkg::RTT_W-1:0]  rtt_q;
	logic [rtcse_pkg::OFF_W-1:0]  quo_q;

	logic [rtcse_pkg::IDX_W-1:0]  write_slot_q;
	logic [rtcse_pkg::CNT_W-1:0]  entry_cnt_q;
	logic [rtcse_pkg::PING_W-1:0] latest_ping_q;
	logic [rtcse_pkg::OFF_W-1:0]  latest_off_q;

	logic [rtcse_pkg::PING_W-1:0] ping_mem [rtcse_pkg::HISTORY_DEPTH];
	logic [rtcse_pkg::OFF_W-1:0]  off_mem  [rtcse_pkg::HISTORY_DEPTH];

	logic [rtcse_pkg::CNT_W-1:0]  walk_idx_q;
	logic                         pend_s1;
	logic [rtcse_pkg::PING_W-1:0] rd_ping_s1;
	logic [rtcse_pkg::OFF_W-1:0]  rd_off_s1;

	logic [rtcse_pkg::ACC_W-1:0]  ping_sum_q;
	logic [rtcse_pkg::ACC_W-1:0]  off_sum_q;
	logic [rtcse_pkg::STAT_W-1:0] min_q, max_q;
	logic [rtcse_pkg::STAT_W-1:0] ping_mean_q;
	logic [1:0]                   div_sel_q;

	logic [rtcse_pkg::PING_W-1:0] res_ping_now_q;
	logic [rtcse_pkg::OFF_W-1:0]  res_offset_q;
	logic [rtcse_pkg::STAT_W-1:0] res_mean_q, res_min_q, res_max_q;
	logic [rtcse_pkg::FILL_W-1:0] res_fill_q;

	logic [rtcse_pkg::TICK_W-1:0]  diff;
	logic [rtcse_pkg::RTT_W-1:0]   rtt;
	logic [rtcse_pkg::PINGX_W-1:0] ping_full;
	logic [rtcse_pkg::PING_W-1:0]  ping_sat;
	logic [rtcse_pkg::RPROD_W-1:0] quo_prod;
	logic [rtcse_pkg::OFF_W-1:0]   off_raw, off_db;
	logic                          off_neg;
	logic [rtcse_pkg::ACC_W-1:0]   off_mag;
	logic                          rd_issue;
	logic [rtcse_pkg::STAT_W-1:0]  rd_ping_x;
	logic [rtcse_pkg::DIV_W-1:0]   div_dividend;
	logic [rtcse_pkg::DVS_W-1:0]   div_divisor;
	logic                          div_done;
	logic [rtcse_pkg::DIV_W-1:0]   div_quo;
	logic [rtcse_pkg::OFF_W-1:0]   div_q32;
	logic                          hist_empty;

	always_comb begin
		diff      = local_q - sent_q;
		rtt       = diff[rtcse_pkg::TICK_W-1] ? '0 : diff[rtcse_pkg::RTT_W-1:0];
		ping_full = rtcse_pkg::PINGX_W'(rtt) * rtcse_pkg::PING_SCALE;
		ping_sat  = (ping_full[rtcse_pkg::PINGX_W-1:rtcse_pkg::PING_W] != '0) ?
			rtcse_pkg::PING_SAT : ping_full[rtcse_pkg::PING_W-1:0];
		quo_prod  = rtcse_pkg::RPROD_W'(rtt_q) * rtcse_pkg::RECIP_3_5;
		off_raw   = quo_q + server_q - local_q;
		off_db    = ($signed(off_raw) >= -rtcse_pkg::DEADBAND &&
			$signed(off_raw) <= rtcse_pkg::DEADBAND) ? '0 : off_raw;
		off_neg   = off_sum_q[rtcse_pkg::ACC_W-1];
		off_mag   = off_neg ? (rtcse_pkg::ACC_W'(0) - off_sum_q) : off_sum_q;
		rd_issue  = cmd.walk_step && (walk_idx_q != entry_cnt_q);
		rd_ping_x = rtcse_pkg::STAT_W'(rd_ping_s1);
		div_q32   = div_quo[rtcse_pkg::OFF_W-1:0];
		hist_empty = (entry_cnt_q == '0);
	end

	always_comb begin
		case (cmd.div_sel)
			rtcse_pkg::DIV_SEL_OFF: begin
				div_dividend = rtcse_pkg::DIV_W'(off_mag);
				div_divisor  = rtcse_pkg::DVS_W'(entry_cnt_q);
			end
			default: begin
				div_dividend = rtcse_pkg::DIV_W'(ping_sum_q);
				div_divisor  = rtcse_pkg::DVS_W'(entry_cnt_q);
			end
		endcase
	end

	rtcse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q  <= '0;
			entry_cnt_q   <= '0;
			latest_ping_q <= '0;
			latest_off_q  <= '0;
			walk_idx_q    <= '0;
			pend_s1       <= 1'b0;
		end else begin
			if (cmd.clear) begin
				write_slot_q <= '0;
				entry_cnt_q  <= '0;
			end else if (cmd.commit) begin
				write_slot_q <= (write_slot_q ==
					rtcse_pkg::IDX_W'(rtcse_pkg::HISTORY_DEPTH - 1)) ? '0 :
					write_slot_q + 1'b1;
				if (entry_cnt_q != rtcse_pkg::CNT_W'(rtcse_pkg::HISTORY_DEPTH)) begin
					entry_cnt_q <= entry_cnt_q + 1'b1;
				end
				latest_ping_q <= ping_new_q;
			end
			if (div_done && div_sel_q == rtcse_pkg::DIV_SEL_OFF) begin
				latest_off_q <= off_neg ? (rtcse_pkg::OFF_W'(0) - div_q32) : div_q32;
			end
			if (cmd.walk_start) begin
				walk_idx_q <= '0;
			end else if (rd_issue) begin
				walk_idx_q <= walk_idx_q + 1'b1;
			end
			pend_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sent_q   <= sent_tick;
			server_q <= server_tick;
			local_q  <= local_tick;
		end
		if (cmd.rtt) begin
			ping_new_q <= ping_sat;
			rtt_q      <= rtt;
		end
		if (cmd.scale) begin
			quo_q <= rtcse_pkg::OFF_W'(
				quo_prod[rtcse_pkg::RPROD_W-1:rtcse_pkg::RECIP_SHIFT]);
		end
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
		end
		if (div_done && div_sel_q == rtcse_pkg::DIV_SEL_PING) begin
			ping_mean_q <= div_q32;
		end
		if (cmd.commit) begin
			ping_mem[write_slot_q] <= ping_new_q;
			off_mem[write_slot_q]  <= off_db;
		end
		if (rd_issue) begin
			rd_ping_s1 <= ping_mem[walk_idx_q[rtcse_pkg::IDX_W-1:0]];
			rd_off_s1  <= off_mem[walk_idx_q[rtcse_pkg::IDX_W-1:0]];
		end
		if (cmd.walk_start) begin
			ping_sum_q <= '0;
			off_sum_q  <= '0;
			min_q      <= rtcse_pkg::EMPTY_MIN;
			max_q      <= '0;
		end else if (pend_s1) begin
			ping_sum_q <= ping_sum_q + rtcse_pkg::ACC_W'(rd_ping_s1);
			off_sum_q  <= off_sum_q + {{(rtcse_pkg::ACC_W - rtcse_pkg::OFF_W)
				{rd_off_s1[rtcse_pkg::OFF_W-1]}}, rd_off_s1};
			if (rd_ping_x < min_q) begin
				min_q <= rd_ping_x;
			end
			if (rd_ping_x > max_q) begin
				max_q <= rd_ping_x;
			end
		end
		if (cmd.result_load) begin
			res_ping_now_q <= latest_ping_q;
			res_offset_q   <= latest_off_q;
			res_mean_q     <= hist_empty ? '0 : ping_mean_q;
			res_min_q      <= hist_empty ? rtcse_pkg::EMPTY_MIN : min_q;
			res_max_q      <= hist_empty ? '0 : max_q;
			res_fill_q     <= rtcse_pkg::FILL_W'(entry_cnt_q);
		end
	end

	assign sts.div_done  = div_done;
	assign sts.walk_done = (walk_idx_q == entry_cnt_q) && !pend_s1;

	assign ping_now     = res_ping_now_q;
	assign offset_mean  = res_offset_q;
	assign ping_mean    = res_mean_q;
	assign ping_min     = res_min_q;
	assign ping_max     = res_max_q;
	assign filled_count = res_fill_q;

endmodule

// ===== src/rtcse_ctrl.sv =====
module rtcse_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_command,
	output logic                  sample_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	output rtcse_pkg::rtcse_cmd_t cmd,
	input  rtcse_pkg::rtcse_sts_t sts
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RTT    = 4'd1;
	localparam logic [3:0] ST_DQ     = 4'd2;
	localparam logic [3:0] ST_COMMIT = 4'd3;
	localparam logic [3:0] ST_WALK   = 4'd4;
	localparam logic [3:0] ST_DOW    = 4'd5;
	localparam logic [3:0] ST_DPW    = 4'd6;
	localparam logic [3:0] ST_DONE   = 4'd7;

	logic [3:0] state_q, state_n;
	logic       result_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.load = 1'b1;
					if (sample_command == rtcse_pkg::CMD_CLEAR) begin
						cmd.clear = 1'b1;
						state_n   = ST_DONE;
					end else begin
						state_n = ST_RTT;
					end
				end
			end
			ST_RTT: begin
				cmd.rtt = 1'b1;
				state_n = ST_DQ;
			end
			ST_DQ: begin
				cmd.scale = 1'b1;
				state_n   = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.walk_start = 1'b1;
				state_n        = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtcse_pkg::DIV_SEL_OFF;
					state_n       = ST_DOW;
				end
			end
			ST_DOW: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = rtcse_pkg::DIV_SEL_PING;
					state_n       = ST_DPW;
				end
			end
			ST_DPW: begin
				if (sts.div_done) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					cmd.result_load = 1'b1;
					state_n         = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

// ===== src/round_trip_clock_sync_estimator_core.sv =====
// channel  | dir | beat contents
// sample   | in  | command, sent_tick, server_tick, local_tick
// result   | out | ping_now, offset_mean, ping_mean, ping_min, ping_max, filled_count
//
// Sample beat: rtt*3/5 by reciprocal multiply, then the history walk with one
// memory read per cycle, then offset and ping means on the shared
// 4-bit-per-cycle divider. Clear beat: the history is emptied and the result loads
// without walk or divide. The next beat is taken in the cycle after the result loads;
// a result still waiting in its register holds the block in its last state. Reset
// clears counters and the latest values; history memories need no clearing.
module round_trip_clock_sync_estimator_core (
	input  logic          clk,
	input  logic          arst_n,
	rtcse_sample_if.sink  sample,
	rtcse_result_if.source result
);

	rtcse_pkg::rtcse_cmd_t cmd;
	rtcse_pkg::rtcse_sts_t sts;

	rtcse_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample.valid),
		.sample_command (sample.command),
		.sample_ready   (sample.ready),
		.result_valid   (result.valid),
		.result_ready   (result.ready),
		.cmd            (cmd),
		.sts            (sts)
	);

	rtcse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sent_tick    (sample.sent_tick),
		.server_tick  (sample.server_tick),
		.local_tick   (sample.local_tick),
		.ping_now     (result.ping_now),
		.offset_mean  (result.offset_mean),
		.ping_mean    (result.ping_mean),
		.ping_min     (result.ping_min),
		.ping_max     (result.ping_max),
		.filled_count (result.filled_count)
	);

endmodule

// ===== src/rtcse_checker.sv =====
module rtcse_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [rtcse_pkg::PING_W-1:0]   ping_now,
	input logic [rtcse_pkg::STAT_W-1:0]   ping_mean,
	input logic [rtcse_pkg::STAT_W-1:0]   ping_min,
	input logic [rtcse_pkg::STAT_W-1:0]   ping_max,
	input logic [rtcse_pkg::FILL_W-1:0]   filled_count
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> filled_count <= rtcse_pkg::FILL_W'(rtcse_pkg::HISTORY_DEPTH))
		else $error("filled_count beyond history depth");

	a_empty_stats: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filled_count == '0 |->
			ping_mean == '0 && ping_min == rtcse_pkg::EMPTY_MIN && ping_max == '0)
		else $error("empty history statistics wrong");

	a_stats_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filled_count != '0 |->
			ping_min <= ping_mean && ping_mean <= ping_max &&
			ping_max <= rtcse_pkg::STAT_W'(rtcse_pkg::PING_SAT))
		else $error("ping statistics out of order");

	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && filled_count == rtcse_pkg::FILL_W'(1) |->
			ping_max == {1'b0, ping_now} && ping_min == {1'b0, ping_now})
		else $error("single entry stats differ from ping_now");

endmodule

bind round_trip_clock_sync_estimator_core rtcse_checker u_rtcse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.ping_now     (result.ping_now),
	.ping_mean    (result.ping_mean),
	.ping_min     (result.ping_min),
	.ping_max     (result.ping_max),
	.filled_count (result.filled_count)
);
